// ----- hw/rtl/pwrbam_pkg.sv -----
// Shared types and constants for the power draw band alarm monitor.
// Holds the request/response payload structs, the config struct and the zone codes.
// No dependencies.
`timescale 1ns / 1ps

package pwrbam_pkg;

   // Zone codes reported per tick
   typedef enum logic [2:0] {
      ZONE_UNKNOWN = 3'd0,
      ZONE_OFF     = 3'd1,
      ZONE_GREEN   = 3'd2,
      ZONE_YELLOW  = 3'd3,
      ZONE_RED     = 3'd4
   } zone_type;

   // Config register indexes
   localparam logic [2:0] REG_MIN_RUNNING_WATTS = 3'd0;
   localparam logic [2:0] REG_BASELINE_Q4       = 3'd1;
   localparam logic [2:0] REG_CALIBRATED        = 3'd2;
   localparam logic [2:0] REG_GREEN_SPAN        = 3'd3;
   localparam logic [2:0] REG_YELLOW_SPAN       = 3'd4;
   localparam logic [2:0] REG_ALARM_DELAY_TICKS = 3'd5;
   localparam logic [2:0] REG_DEBOUNCE_COUNT    = 3'd6;
   localparam logic [2:0] REG_FAIL_LIMIT        = 3'd7;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Config reset values
   localparam logic [15:0] RST_MIN_RUNNING_WATTS = 16'd5;
   localparam logic [15:0] RST_BASELINE_Q4       = 16'd0;
   localparam logic        RST_CALIBRATED        = 1'b0;
   localparam logic [6:0]  RST_GREEN_SPAN        = 7'd10;
   localparam logic [6:0]  RST_YELLOW_SPAN       = 7'd20;
   localparam logic [15:0] RST_ALARM_DELAY_TICKS = 16'd30;
   localparam logic [7:0]  RST_DEBOUNCE_COUNT    = 8'd2;
   localparam logic [7:0]  RST_FAIL_LIMIT        = 8'd3;

   localparam logic [7:0]  STREAK_MAX = 8'hFF;
   localparam logic [15:0] TICKS_MAX  = 16'hFFFF;

   typedef struct packed {
      logic        calibrating;
      logic        link_up;
      logic        plug_present;
      logic        read_ok;
      logic [15:0] reading_watts;
   } req_type;

   typedef struct packed {
      zone_type    zone;
      logic        alarm;
      logic        running;
      logic        online;
      logic        reading_valid;
      logic [15:0] cached_watts;
   } rsp_type;

   typedef struct packed {
      logic [15:0] min_running_watts;
      logic [15:0] baseline_q4;
      logic        calibrated;
      logic [6:0]  green_span;
      logic [6:0]  yellow_span;
      logic [15:0] alarm_delay_ticks;
      logic [7:0]  debounce_count;
      logic [7:0]  fail_limit;
   } cfg_type;

endpackage

// ----- hw/rtl/pwrbam_zone.sv -----
// Zone classifier: maps the cached reading to unknown/off/green/yellow/red.
// Band edges are compared exactly as W*1600 against baseline_q4*(100 -/+ pct).
// Depends on pwrbam_pkg.
`timescale 1ns / 1ps

module pwrbam_zone (
   input  pwrbam_pkg::cfg_type  cfg,
   input  logic                 held_valid,
   input  logic [15:0]          held_watts,
   output pwrbam_pkg::zone_type zone
);

   logic        [26:0] wl_u;
   logic signed [28:0] wl;
   logic signed [16:0] base_s;
   logic signed [7:0]  green_lo_f;
   logic signed [7:0]  yellow_lo_f;
   logic        [8:0]  green_hi_f;
   logic        [8:0]  yellow_hi_f;
   logic signed [24:0] green_lo_p;
   logic signed [24:0] yellow_lo_p;
   logic        [24:0] green_hi_p;
   logic        [24:0] yellow_hi_p;
   logic signed [28:0] glo;
   logic signed [28:0] ylo;
   logic signed [28:0] ghi;
   logic signed [28:0] yhi;
   logic               in_green;
   logic               in_yellow;

   // Scale watts by 1600 (1024 + 512 + 64) to match the Q12.4 percent products
   assign wl_u = {1'b0, held_watts, 10'b0} + {2'b0, held_watts, 9'b0}
               + {5'b0, held_watts, 6'b0};
   assign wl   = $signed({2'b00, wl_u});

   // Band factors; the low factor goes negative for percents above 100
   assign base_s      = $signed({1'b0, cfg.baseline_q4});
   assign green_lo_f  = 8'sd100 - $signed({1'b0, cfg.green_span});
   assign yellow_lo_f = 8'sd100 - $signed({1'b0, cfg.yellow_span});
   assign green_hi_f  = 9'd100 + {2'b0, cfg.green_span};
   assign yellow_hi_f = 9'd100 + {2'b0, cfg.yellow_span};

   assign green_lo_p  = 25'(base_s) * 25'(green_lo_f);
   assign yellow_lo_p = 25'(base_s) * 25'(yellow_lo_f);
   assign green_hi_p  = {9'b0, cfg.baseline_q4} * {16'b0, green_hi_f};
   assign yellow_hi_p = {9'b0, cfg.baseline_q4} * {16'b0, yellow_hi_f};

   assign glo = {{4{green_lo_p[24]}}, green_lo_p};
   assign ylo = {{4{yellow_lo_p[24]}}, yellow_lo_p};
   assign ghi = $signed({4'b0, green_hi_p});
   assign yhi = $signed({4'b0, yellow_hi_p});

   assign in_green  = (wl >= glo) && (wl <= ghi);
   assign in_yellow = ((wl >= ylo) && (wl < glo)) || ((wl > ghi) && (wl <= yhi));

   // Pick the zone, validity and off checks first
   always_comb begin
      if (!held_valid) begin
         zone = pwrbam_pkg::ZONE_UNKNOWN;
      end else if (held_watts <= cfg.min_running_watts) begin
         zone = pwrbam_pkg::ZONE_OFF;
      end else if (!cfg.calibrated) begin
         zone = pwrbam_pkg::ZONE_UNKNOWN;
      end else if (in_green) begin
         zone = pwrbam_pkg::ZONE_GREEN;
      end else if (in_yellow) begin
         zone = pwrbam_pkg::ZONE_YELLOW;
      end else begin
         zone = pwrbam_pkg::ZONE_RED;
      end
   end

endmodule

// ----- hw/rtl/power_draw_band_alarm_monitor.sv -----
// Top level of the power draw band alarm monitor: request register, read-stage
// state update, zone/alarm evaluation and response register. Depends on
// pwrbam_pkg and pwrbam_zone.
`timescale 1ns / 1ps

//  channel  | ports                              | direction | moves
//  ---------+------------------------------------+-----------+-------------------------
//  request  | req_valid, req_stall, req_data     | in        | one poll tick
//  response | rsp_valid, rsp_stall, rsp_data     | out       | zone, alarm, cached read
//  config   | csr_wr_en, csr_index, csr_wdata    | in        | one register write
//
// One request per cycle sustained while rsp_stall is low; a request's response shows on
// rsp_data once it has been accepted and has passed the request register, then the state
// update into the response register, where it is held until it is taken.
// Reset restores the register defaults and clears all tick state and both stages.
// A stalled response holds its stage; the request register keeps taking a request
// as long as it is empty or can move into the response register.

module power_draw_band_alarm_monitor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  pwrbam_pkg::req_type                  req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output pwrbam_pkg::rsp_type                  rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [pwrbam_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pwrbam_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // Config registers
   pwrbam_pkg::cfg_type cfg_ff, cfg_in;

   // Pipeline stages
   logic                req_valid_ff, req_valid_in;
   pwrbam_pkg::req_type req_data_ff, req_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pwrbam_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Tick state
   logic [15:0] held_watts_ff, held_watts_in;
   logic        held_valid_ff, held_valid_in;
   logic        is_on_ff, is_on_in;
   logic        is_online_ff, is_online_in;
   logic [7:0]  high_streak_ff, high_streak_in;
   logic [7:0]  low_streak_ff, low_streak_in;
   logic [7:0]  fail_streak_ff, fail_streak_in;
   logic        abn_active_ff, abn_active_in;
   logic [15:0] abn_ticks_ff, abn_ticks_in;

   logic                 accept;
   logic                 advance;
   logic [7:0]           low_inc;
   logic [7:0]           high_inc;
   logic [7:0]           fail_inc;
   logic [15:0]          ticks_inc;
   logic                 alarm;
   pwrbam_pkg::zone_type zone;

   // Handshake: the request stage moves when the response stage is free or draining
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Config write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            pwrbam_pkg::REG_MIN_RUNNING_WATTS: cfg_in.min_running_watts = csr_wdata;
            pwrbam_pkg::REG_BASELINE_Q4:       cfg_in.baseline_q4       = csr_wdata;
            pwrbam_pkg::REG_CALIBRATED:        cfg_in.calibrated        = csr_wdata[0];
            pwrbam_pkg::REG_GREEN_SPAN:        cfg_in.green_span        = csr_wdata[6:0];
            pwrbam_pkg::REG_YELLOW_SPAN:       cfg_in.yellow_span       = csr_wdata[6:0];
            pwrbam_pkg::REG_ALARM_DELAY_TICKS: cfg_in.alarm_delay_ticks = csr_wdata;
            pwrbam_pkg::REG_DEBOUNCE_COUNT:    cfg_in.debounce_count    = csr_wdata[7:0];
            pwrbam_pkg::REG_FAIL_LIMIT:        cfg_in.fail_limit        = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Saturating increments
   assign low_inc   = (low_streak_ff == pwrbam_pkg::STREAK_MAX) ? low_streak_ff
                                                                : low_streak_ff + 8'd1;
   assign high_inc  = (high_streak_ff == pwrbam_pkg::STREAK_MAX) ? high_streak_ff
                                                                 : high_streak_ff + 8'd1;
   assign fail_inc  = (fail_streak_ff == pwrbam_pkg::STREAK_MAX) ? fail_streak_ff
                                                                 : fail_streak_ff + 8'd1;
   assign ticks_inc = (abn_ticks_ff == pwrbam_pkg::TICKS_MAX) ? abn_ticks_ff
                                                              : abn_ticks_ff + 16'd1;

   // Read stage: calibrating, then link, then plug, then read result
   always_comb begin
      held_watts_in  = held_watts_ff;
      held_valid_in  = held_valid_ff;
      is_on_in       = is_on_ff;
      is_online_in   = is_online_ff;
      high_streak_in = high_streak_ff;
      low_streak_in  = low_streak_ff;
      fail_streak_in = fail_streak_ff;
      if (advance && !req_data_ff.calibrating) begin
         if (!req_data_ff.link_up) begin
            is_online_in = 1'b0;
         end else if (!req_data_ff.plug_present) begin
            is_online_in   = 1'b0;
            held_valid_in  = 1'b0;
            is_on_in       = 1'b0;
            fail_streak_in = 8'd0;
            high_streak_in = 8'd0;
            low_streak_in  = 8'd0;
         end else if (req_data_ff.read_ok) begin
            is_online_in   = 1'b1;
            fail_streak_in = 8'd0;
            if (req_data_ff.reading_watts <= cfg_ff.min_running_watts) begin
               high_streak_in = 8'd0;
               low_streak_in  = low_inc;
               if (low_inc >= cfg_ff.debounce_count) begin
                  held_watts_in = req_data_ff.reading_watts;
                  held_valid_in = 1'b1;
                  is_on_in      = 1'b0;
               end
            end else begin
               low_streak_in  = 8'd0;
               high_streak_in = high_inc;
               if (high_inc >= cfg_ff.debounce_count) begin
                  held_watts_in = req_data_ff.reading_watts;
                  held_valid_in = 1'b1;
                  is_on_in      = 1'b1;
               end
            end
         end else begin
            is_online_in   = 1'b0;
            fail_streak_in = fail_inc;
            if (fail_inc >= cfg_ff.fail_limit) begin
               held_watts_in = 16'd0;
               held_valid_in = 1'b1;
               is_on_in      = 1'b0;
            end
         end
      end
   end

   // Classify the updated cached reading
   pwrbam_zone u_zone (
      .cfg        (cfg_ff),
      .held_valid (held_valid_in),
      .held_watts (held_watts_in),
      .zone       (zone)
   );

   // Abnormal persistence tracking; the first abnormal tick never alarms
   always_comb begin
      abn_active_in = abn_active_ff;
      abn_ticks_in  = abn_ticks_ff;
      alarm         = 1'b0;
      if (advance) begin
         if (zone == pwrbam_pkg::ZONE_YELLOW || zone == pwrbam_pkg::ZONE_RED) begin
            if (!abn_active_ff) begin
               abn_active_in = 1'b1;
               abn_ticks_in  = 16'd0;
            end else begin
               abn_ticks_in = ticks_inc;
               alarm        = (ticks_inc >= cfg_ff.alarm_delay_ticks);
            end
         end else begin
            abn_active_in = 1'b0;
            abn_ticks_in  = 16'd0;
         end
      end
   end

   // Stage next values
   always_comb begin
      req_valid_in = accept || (req_valid_ff && !advance);
      req_data_in  = accept ? req_data : req_data_ff;
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_data_in.zone          = zone;
         rsp_data_in.alarm         = alarm;
         rsp_data_in.running       = held_valid_in && is_on_in;
         rsp_data_in.online        = is_online_in;
         rsp_data_in.reading_valid = held_valid_in;
         rsp_data_in.cached_watts  = held_watts_in;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_running_watts <= pwrbam_pkg::RST_MIN_RUNNING_WATTS;
         cfg_ff.baseline_q4       <= pwrbam_pkg::RST_BASELINE_Q4;
         cfg_ff.calibrated        <= pwrbam_pkg::RST_CALIBRATED;
         cfg_ff.green_span        <= pwrbam_pkg::RST_GREEN_SPAN;
         cfg_ff.yellow_span       <= pwrbam_pkg::RST_YELLOW_SPAN;
         cfg_ff.alarm_delay_ticks <= pwrbam_pkg::RST_ALARM_DELAY_TICKS;
         cfg_ff.debounce_count    <= pwrbam_pkg::RST_DEBOUNCE_COUNT;
         cfg_ff.fail_limit        <= pwrbam_pkg::RST_FAIL_LIMIT;
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         held_watts_ff  <= 16'd0;
         held_valid_ff  <= 1'b0;
         is_on_ff       <= 1'b0;
         is_online_ff   <= 1'b0;
         high_streak_ff <= 8'd0;
         low_streak_ff  <= 8'd0;
         fail_streak_ff <= 8'd0;
         abn_active_ff  <= 1'b0;
         abn_ticks_ff   <= 16'd0;
      end else begin
         cfg_ff         <= cfg_in;
         req_valid_ff   <= req_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         held_watts_ff  <= held_watts_in;
         held_valid_ff  <= held_valid_in;
         is_on_ff       <= is_on_in;
         is_online_ff   <= is_online_in;
         high_streak_ff <= high_streak_in;
         low_streak_ff  <= low_streak_in;
         fail_streak_ff <= fail_streak_in;
         abn_active_ff  <= abn_active_in;
         abn_ticks_ff   <= abn_ticks_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
